// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/vnr_pkg.sv -----
// Shared types and constants for the vector normalizer
package vnr_pkg;
    localparam int SqW   = 32;              // squared length width
    localparam int LenW  = 18;              // root width
    localparam int SqrtSteps = LenW;        // one root bit per cell
    localparam int NumW  = 40;              // radius << 24
    localparam int QW    = 41;              // quotient width
    localparam int DivSteps = NumW;         // one numerator bit per cell
    localparam int OutW  = 24;

    typedef struct packed {
        logic              vld;
        logic              zero;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]       rad;
    } t_tag;

    typedef struct packed {
        t_tag             tag;
        logic [35:0]      rem;   // remaining radicand
        logic [LenW-1:0]  root;
        logic [5:0]       idx;   // current pair index
    } t_sq;

    typedef struct packed {
        t_tag              tag;
        logic [NumW-1:0]   num;
        logic [LenW:0]     rem;
        logic [LenW-1:0]   den;
        logic [QW-1:0]     quo;
    } t_dv;
endpackage

// ----- design/vnr_sqrt_cell.sv -----
// One restoring square-root cell: resolves one root bit per cycle
module vnr_sqrt_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  vnr_pkg::t_sq i_d,
    output vnr_pkg::t_sq o_d
);
    import vnr_pkg::*;
    t_sq         n_d;
    t_sq         r_d;
    logic [37:0] trial;
    logic [37:0] curr;

    // Try to append a one to the root
    always_comb begin
        n_d  = i_d;
        curr = {i_d.rem, 2'b00} >> 0;
        trial = {18'd0, i_d.root, 2'b01};
        curr = {2'b00, i_d.rem};
        n_d.rem = i_d.rem;
        n_d.root = {i_d.root[LenW-2:0], 1'b0};
        if ((curr >> (2 * i_d.idx)) >= {trial[35:0], 2'b00} >> 2) begin
            n_d.rem  = 36'(curr - (trial << (2 * i_d.idx)));
            n_d.root = {i_d.root[LenW-2:0], 1'b1};
        end
        n_d.idx = i_d.idx - 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.tag.vld <= 1'b0;
        end else begin
            r_d.tag.vld <= i_d.tag.vld;
        end
        r_d.tag.zero <= n_d.tag.zero;
        r_d.tag.x    <= n_d.tag.x;
        r_d.tag.y    <= n_d.tag.y;
        r_d.tag.z    <= n_d.tag.z;
        r_d.tag.rad  <= n_d.tag.rad;
        r_d.rem      <= n_d.rem;
        r_d.root     <= n_d.root;
        r_d.idx      <= n_d.idx;
    end
    assign o_d = r_d;
endmodule

// ----- design/vnr_div_cell.sv -----
// One restoring divider cell: resolves one quotient bit per cycle
module vnr_div_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  vnr_pkg::t_dv i_d,
    output vnr_pkg::t_dv o_d
);
    import vnr_pkg::*;
    t_dv          n_d;
    t_dv          r_d;
    logic [LenW:0] sh;

    // Shift in the next numerator bit and subtract if it fits
    always_comb begin
        n_d = i_d;
        sh  = {i_d.rem[LenW-1:0], i_d.num[NumW-1]};
        n_d.num = {i_d.num[NumW-2:0], 1'b0};
        n_d.quo = {i_d.quo[QW-2:0], 1'b0};
        n_d.rem = sh;
        if (sh >= {1'b0, i_d.den}) begin
            n_d.rem = sh - {1'b0, i_d.den};
            n_d.quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.tag.vld <= 1'b0;
        end else begin
            r_d.tag.vld <= i_d.tag.vld;
        end
        r_d.tag.zero <= n_d.tag.zero;
        r_d.tag.x    <= n_d.tag.x;
        r_d.tag.y    <= n_d.tag.y;
        r_d.tag.z    <= n_d.tag.z;
        r_d.tag.rad  <= n_d.tag.rad;
        r_d.num      <= n_d.num;
        r_d.rem      <= n_d.rem;
        r_d.den      <= n_d.den;
        r_d.quo      <= n_d.quo;
    end
    assign o_d = r_d;
endmodule

// ----- design/vector_normalize_to_radius.sv -----
// Top level: squared length, root cell chain, divider cell chain, scaling
//
//  channel | direction | handshake        | payload
//  input   | in        | i_start / o_busy | i_pos_x, i_pos_y, i_pos_z
//  result  | out       | o_valid strobe   | o_out_x, o_out_y, o_out_z, o_zero_length
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_data
//
// One vertex enters every cycle; o_busy stays low. Each vertex passes through the
// squares register, 18 root cells, 40 divider cells, and then the scaling registers.
// Reset clears all valid flags and sets the radius to 1.0. Results cannot be
// stalled. The radius is sampled when a vertex enters.
module vector_normalize_to_radius (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic signed [23:0] o_out_x,
    output logic signed [23:0] o_out_y,
    output logic signed [23:0] o_out_z,
    output logic        o_zero_length
);
    import vnr_pkg::*;
    `include "assert_macros.svh"

    logic [15:0] r_rad;
    t_tag        r_t0;
    logic [SqW-1:0] r_sq;
    t_sq         sq_c [0:SqrtSteps];
    t_dv         dv_c [0:DivSteps];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Hold the radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad <= 16'd256;
        end else if (i_cfg_valid) begin
            r_rad <= i_cfg_data;
        end
    end

    // Square and sum the coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0.vld <= 1'b0;
        end else begin
            r_t0.vld <= i_start;
        end
        r_t0.x    <= i_pos_x;
        r_t0.y    <= i_pos_y;
        r_t0.z    <= i_pos_z;
        r_t0.rad  <= r_rad;
        r_t0.zero <= (i_pos_x == 16'sd0) && (i_pos_y == 16'sd0) && (i_pos_z == 16'sd0);
        r_sq <= SqW'(32'(i_pos_x * i_pos_x)) + SqW'(32'(i_pos_y * i_pos_y))
              + SqW'(32'(i_pos_z * i_pos_z));
    end

    // Feed the root chain with S*16
    always_comb begin
        sq_c[0].tag  = r_t0;
        sq_c[0].rem  = {r_sq, 4'd0};
        sq_c[0].root = '0;
        sq_c[0].idx  = 6'(SqrtSteps - 1);
    end

    for (genvar g = 0; g < SqrtSteps; g++) begin : g_sq
        vnr_sqrt_cell u_cell (.i_clk(i_clk), .i_rst_n(i_rst_n),
                              .i_d(sq_c[g]), .o_d(sq_c[g+1]));
    end

    // Feed the divider chain with radius << 24 over the root
    always_comb begin
        dv_c[0].tag = sq_c[SqrtSteps].tag;
        dv_c[0].num = {sq_c[SqrtSteps].tag.rad, 24'd0};
        dv_c[0].rem = '0;
        dv_c[0].den = (sq_c[SqrtSteps].root == '0) ? LenW'(1) : sq_c[SqrtSteps].root;
        dv_c[0].quo = '0;
    end

    for (genvar g = 0; g < DivSteps; g++) begin : g_dv
        vnr_div_cell u_cell (.i_clk(i_clk), .i_rst_n(i_rst_n),
                             .i_d(dv_c[g]), .o_d(dv_c[g+1]));
    end

    // Scale: split the 16x41 product into two registered halves
    t_tag r_s1, r_s2, r_s3;
    logic [QW-1:0] q;
    logic [15:0] m [0:2];
    logic        ng [0:2];
    logic [15:0] r_m [0:2];
    logic        r_ng [0:2];
    logic        r_ng1 [0:2];
    logic        r_ng2 [0:2];
    logic [QW-1:0] r_q;
    logic [36:0] r_lo [0:2];
    logic [36:0] r_hi [0:2];
    logic [56:0] r_pr [0:2];
    logic [23:0] r_o  [0:2];
    logic [56:0] rnd  [0:2];
    logic [23:0] sat  [0:2];

    assign q = dv_c[DivSteps].quo;
    always_comb begin
        m[0] = dv_c[DivSteps].tag.x[15] ? 16'(-dv_c[DivSteps].tag.x) : dv_c[DivSteps].tag.x;
        m[1] = dv_c[DivSteps].tag.y[15] ? 16'(-dv_c[DivSteps].tag.y) : dv_c[DivSteps].tag.y;
        m[2] = dv_c[DivSteps].tag.z[15] ? 16'(-dv_c[DivSteps].tag.z) : dv_c[DivSteps].tag.z;
        ng[0] = dv_c[DivSteps].tag.x[15];
        ng[1] = dv_c[DivSteps].tag.y[15];
        ng[2] = dv_c[DivSteps].tag.z[15];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd[k] = (r_pr[k] + 57'd32768) >> 16;
            if (r_ng2[k]) begin
                sat[k] = (rnd[k] > 57'd8388608) ? 24'h800000 : 24'(-rnd[k]);
            end else begin
                sat[k] = (rnd[k] > 57'd8388607) ? 24'h7FFFFF : rnd[k][23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_s1.vld <= dv_c[DivSteps].tag.vld;
            r_s2.vld <= r_s1.vld;
            r_s3.vld <= r_s2.vld;
            o_valid  <= r_s3.vld;
        end
        r_s1.zero <= dv_c[DivSteps].tag.zero;
        r_s1.x <= '0; r_s1.y <= '0; r_s1.z <= '0; r_s1.rad <= '0;
        r_s2.zero <= r_s1.zero;
        r_s2.x <= '0; r_s2.y <= '0; r_s2.z <= '0; r_s2.rad <= '0;
        r_s3.zero <= r_s2.zero;
        r_s3.x <= '0; r_s3.y <= '0; r_s3.z <= '0; r_s3.rad <= '0;
        r_q <= q;
        for (int k = 0; k < 3; k++) begin
            r_m[k]  <= m[k];
            r_ng[k] <= ng[k];
            r_lo[k] <= 37'(r_m[k] * r_q[20:0]);
            r_hi[k] <= 37'(r_m[k] * r_q[40:21]);
            r_pr[k] <= 57'(r_lo[k]) + (57'(r_hi[k]) << 21);
            r_o[k]  <= r_s3.zero ? 24'd0 : sat[k];
        end
        o_zero_length <= r_s3.zero;
    end

    // Delay the sign flags so they line up with the product
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ng1[k] <= r_ng[k];
            r_ng2[k] <= r_ng1[k];
        end
    end

    assign o_out_x = r_o[0];
    assign o_out_y = r_o[1];
    assign o_out_z = r_o[2];

    `ASSERT_IMPL(a_zero_out, i_clk, i_rst_n, o_valid && o_zero_length,
        o_out_x == 24'd0 && o_out_y == 24'd0 && o_out_z == 24'd0, "zero vector not zero")
    `ASSERT_NEXT(a_busy_low, i_clk, i_rst_n, 1'b1, !o_busy, "busy raised")
    `ASSERT_NEXT(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready, "config ready dropped")
endmodule
